// ===== src/fca_pkg.sv =====
// Shared types and codes for the first-fit coalescing allocator.
// No dependencies; imported by the extent cell and the top level.
package fca_pkg;

  // Width of the rounded allocation size: 16-bit request plus header and alignment.
  localparam int SIZE_W = 18;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE,
    OP_INIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load_valid;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_CMP,
    ST_A_SEL,
    ST_A_APPLY,
    ST_F_RD,
    ST_F_END,
    ST_F_CMP,
    ST_F_SEL,
    ST_F_APPLY,
    ST_F_REM,
    ST_DONE
  } fca_state_t;

endpackage

// ===== src/first_fit_coalescing_allocator_top.sv =====
// First-fit free-list allocator with coalescing over a fixed arena. Free extents live in a
// chain of MAX_FREE_EXTENTS cells kept sorted by address; every cell compares its extent
// against the broadcast request in parallel, and inserts and removals shift the chain by one
// cell. Block sizes are kept in a store of ARENA_BYTES/ALIGN_BYTES words with one write port
// and a registered read. One word is in flight at a time: allocates, frees and rejected free
// offsets each complete before the next word is taken, and a free that merges with both
// neighbors needs a separate removal shift. A free waits on the registered size-store read
// and on the per-cell compare register. Writing cfg_active_pool_bytes reloads the chain with
// one extent covering the pool; a pending configuration write holds off the input so that
// no word is in flight when it lands.
// Depends on fca_pkg and fca_cell.
module first_fit_coalescing_allocator_top #(
  parameter int ARENA_BYTES      = 65536,
  parameter int ALIGN_BYTES      = 16,
  parameter int HEADER_BYTES     = 16,
  parameter int MIN_FREE_BYTES   = 16,
  parameter int MAX_FREE_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_data_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_active_pool_bytes
);
  import fca_pkg::*;

  localparam int N   = MAX_FREE_EXTENTS;
  localparam int AW  = $clog2(ARENA_BYTES);
  localparam int LW  = AW + 1;
  localparam int SW  = AW + 2;
  localparam int KW  = (SW + 1 > SIZE_W) ? SW + 1 : SIZE_W;
  localparam int SD  = ARENA_BYTES / ALIGN_BYTES;
  localparam int IW  = $clog2(SD);
  localparam int ASH = $clog2(ALIGN_BYTES);
  localparam logic [LW:0]   LEN_CAP  = (LW+1)'(2 * ARENA_BYTES - 1);
  localparam logic [LW-1:0] POOL_RST = LW'((ARENA_BYTES / ALIGN_BYTES) * ALIGN_BYTES);
  localparam logic [KW-1:0] ALIGN_M  = KW'(ALIGN_BYTES - 1);

  function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > LEN_CAP) ? LEN_CAP[LW-1:0] : s[LW-1:0];
  endfunction

  fca_state_t state_r, state_nxt;

  // Cell chain wiring
  cell_cmd_t     cmd;
  logic [N-1:0]  pos, after;
  logic [SW-1:0] w_start;
  logic [LW-1:0] w_len;
  logic [N-1:0]  v_vec, fit_vec, gt_vec, eq_vec, adj_vec;
  logic [SW-1:0] c_start [N];
  logic [LW-1:0] c_len   [N];

  // Request registers
  logic [KW-1:0] size_r, e_r, end_r;
  logic [LW-1:0] sz_r, rd_r, pool_r;
  logic [N-1:0]  sel_r, kone_r;
  logic [SW-1:0] selstart_r, startk_r;
  logic [LW-1:0] sellen_r, lenk_r, lenk1_r;
  logic          nofit_r, mn_r, mp_r, c0_r, ceq0_r;
  logic [15:0]   res_data_r, res_data_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_load;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic [1:0]    out_status_r;

  // Size store
  logic [LW-1:0] mem [SD];
  logic          mem_we;
  logic [IW-1:0] mem_widx;
  logic [LW-1:0] mem_wdata;
  logic [IW-1:0] e_idx;

  logic in_acc, cfg_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;
  // hold the input while a configuration word is offered
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic          lv, rv;
      logic [SW-1:0] ls, rs;
      logic [LW-1:0] ll, rl;
      if (g == 0) begin : g_l0
        assign lv = 1'b0;
        assign ls = '0;
        assign ll = '0;
      end else begin : g_ln
        assign lv = v_vec[g-1];
        assign ls = c_start[g-1];
        assign ll = c_len[g-1];
      end
      if (g == N - 1) begin : g_rl
        assign rv = 1'b0;
        assign rs = '0;
        assign rl = '0;
      end else begin : g_rn
        assign rv = v_vec[g+1];
        assign rs = c_start[g+1];
        assign rl = c_len[g+1];
      end
      fca_cell #(
        .SW(SW), .LW(LW), .KW(KW),
        .RST_VALID(g == 0 && POOL_RST != '0),
        .RST_LEN((g == 0) ? POOL_RST : '0)
      ) u_cell (
        .clk, .rst_n, .cmd,
        .pos_i(pos[g]), .after_i(after[g]),
        .w_start, .w_len,
        .l_valid(lv), .l_start(ls), .l_len(ll),
        .r_valid(rv), .r_start(rs), .r_len(rl),
        .probe_size(size_r), .probe_end(end_r), .probe_base(e_r),
        .valid_o(v_vec[g]), .start_o(c_start[g]), .len_o(c_len[g]),
        .fit_o(fit_vec[g]), .gt_o(gt_vec[g]), .eq_o(eq_vec[g]), .adj_o(adj_vec[g])
      );
    end
  endgenerate

  // Cells past the command position shift
  assign after = ~(pos | (pos - N'(1)));

  // Accept-time decode
  logic [KW-1:0] req_sum, req_min, req_size;
  logic [31:0]   off32, cfg32, cfg_sat;
  logic          bad_off;
  logic [LW-1:0] pool_new;

  always_comb begin
    req_sum  = KW'(in_request_bytes) + KW'(HEADER_BYTES);
    req_min  = (req_sum < KW'(MIN_FREE_BYTES)) ? KW'(MIN_FREE_BYTES) : req_sum;
    req_size = (req_min + ALIGN_M) & ~ALIGN_M;
    off32    = 32'(in_block_offset);
    bad_off  = (off32 < 32'(HEADER_BYTES)) || (off32 >= 32'(pool_r)) ||
               (((off32 - 32'(HEADER_BYTES)) & 32'(ALIGN_BYTES - 1)) != 32'd0);
    cfg32    = 32'(cfg_active_pool_bytes);
    cfg_sat  = (cfg32 > 32'(ARENA_BYTES)) ? 32'(ARENA_BYTES) : cfg32;
    pool_new = LW'(cfg_sat & ~32'(ALIGN_BYTES - 1));
  end

  // First-fit and neighbor search over the registered cell flags
  logic [N-1:0]  fit_first, stop, stop_first, kone, kone1;
  logic [SW-1:0] g_selstart, g_startk;
  logic [LW-1:0] g_sellen, g_lenk, g_lenk1;

  always_comb begin
    fit_first  = fit_vec & (~fit_vec + N'(1));
    stop       = v_vec & ~gt_vec & ~N'(1);
    stop_first = stop & (~stop + N'(1));
    kone       = (stop_first != '0) ? (stop_first >> 1) : (v_vec & ~(v_vec >> 1));
    kone1      = {kone[N-2:0], 1'b0};
    g_selstart = '0;
    g_sellen   = '0;
    g_startk   = '0;
    g_lenk     = '0;
    g_lenk1    = '0;
    for (int j = 0; j < N; j++) begin
      g_selstart = g_selstart | (c_start[j] & {SW{fit_first[j]}});
      g_sellen   = g_sellen   | (c_len[j]   & {LW{fit_first[j]}});
      g_startk   = g_startk   | (c_start[j] & {SW{kone[j]}});
      g_lenk     = g_lenk     | (c_len[j]   & {LW{kone[j]}});
      g_lenk1    = g_lenk1    | (c_len[j]   & {LW{kone1[j]}});
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ALLOC) state_nxt = ST_A_CMP;
          else if (bad_off)          state_nxt = ST_DONE;
          else                       state_nxt = ST_F_RD;
        end
      end
      ST_A_CMP:   state_nxt = ST_A_SEL;
      ST_A_SEL:   state_nxt = ST_A_APPLY;
      ST_A_APPLY: state_nxt = ST_DONE;
      ST_F_RD:    state_nxt = ST_F_END;
      ST_F_END:   state_nxt = ST_F_CMP;
      ST_F_CMP:   state_nxt = ST_F_SEL;
      ST_F_SEL:   state_nxt = ST_F_APPLY;
      ST_F_APPLY: state_nxt = (!c0_r && !ceq0_r && mn_r && mp_r) ? ST_F_REM : ST_DONE;
      ST_F_REM:   state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Cell commands, size-store write and result
  logic [KW-1:0] a_diff;
  logic          full;
  assign a_diff = KW'(sellen_r) - size_r;
  assign full   = v_vec[N-1];

  always_comb begin
    cmd            = '{op: OP_HOLD, load_valid: 1'b0};
    pos            = '0;
    w_start        = '0;
    w_len          = '0;
    mem_we         = 1'b0;
    mem_widx       = selstart_r[ASH +: IW];
    mem_wdata      = sellen_r;
    res_load       = 1'b0;
    res_data_nxt   = '0;
    res_status_nxt = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          cmd     = '{op: OP_INIT, load_valid: (pool_new != '0)};
          pos     = N'(1);
          w_len   = pool_new;
        end
        if (in_acc && in_mode == MODE_FREE && bad_off) begin
          res_load       = 1'b1;
          res_status_nxt = STAT_BADADDR;
        end
      end
      ST_A_APPLY: begin
        res_load = 1'b1;
        if (nofit_r) begin
          res_status_nxt = STAT_NOFIT;
        end else begin
          pos          = sel_r;
          res_data_nxt = 16'(KW'(selstart_r) + KW'(HEADER_BYTES));
          mem_we       = (KW'(selstart_r) < KW'(ARENA_BYTES));
          if (a_diff >= KW'(MIN_FREE_BYTES)) begin
            cmd       = '{op: OP_WRITE, load_valid: 1'b1};
            w_start   = SW'(KW'(selstart_r) + size_r);
            w_len     = LW'(a_diff);
            mem_wdata = LW'(size_r);
          end else begin
            cmd = '{op: OP_REMOVE, load_valid: 1'b0};
          end
        end
      end
      ST_F_APPLY: begin
        res_load = 1'b1;
        w_start  = SW'(e_r);
        w_len    = sz_r;
        if (c0_r) begin
          pos = N'(1);
          if (full) res_status_nxt = STAT_FULL;
          else      cmd = '{op: OP_INSERT, load_valid: 1'b1};
        end else if (ceq0_r) begin
          pos   = N'(1);
          cmd   = '{op: OP_WRITE, load_valid: 1'b1};
          w_len = sat_add(c_len[0], sz_r);
        end else if (!mn_r && !mp_r) begin
          pos = {kone_r[N-2:0], 1'b0};
          if (full) res_status_nxt = STAT_FULL;
          else      cmd = '{op: OP_INSERT, load_valid: 1'b1};
        end else if (!mp_r) begin
          pos   = {kone_r[N-2:0], 1'b0};
          cmd   = '{op: OP_WRITE, load_valid: 1'b1};
          w_len = sat_add(sz_r, lenk1_r);
        end else begin
          pos     = kone_r;
          cmd     = '{op: OP_WRITE, load_valid: 1'b1};
          w_start = startk_r;
          w_len   = mn_r ? sat_add(lenk_r, sat_add(sz_r, lenk1_r)) : sat_add(lenk_r, sz_r);
        end
      end
      ST_F_REM: begin
        // drop the absorbed following extent
        pos = {kone_r[N-2:0], 1'b0};
        cmd = '{op: OP_REMOVE, load_valid: 1'b0};
      end
      default: ;
    endcase
  end

  assign e_idx = e_r[ASH +: IW];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    rd_r <= mem[e_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pool_r      <= POOL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) pool_r <= pool_new;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      size_r <= req_size;
      e_r    <= KW'(in_block_offset) - KW'(HEADER_BYTES);
      end_r  <= '1;
    end
    if (state_r == ST_F_END) begin
      sz_r  <= rd_r;
      end_r <= e_r + KW'(rd_r);
    end
    if (state_r == ST_A_SEL) begin
      sel_r      <= fit_first;
      nofit_r    <= (fit_vec == '0);
      selstart_r <= g_selstart;
      sellen_r   <= g_sellen;
    end
    if (state_r == ST_F_SEL) begin
      kone_r   <= kone;
      mn_r     <= |(stop_first & eq_vec);
      mp_r     <= |(kone & adj_vec);
      c0_r     <= !v_vec[0] || (!gt_vec[0] && !eq_vec[0]);
      ceq0_r   <= v_vec[0] && eq_vec[0];
      startk_r <= g_startk;
      lenk_r   <= g_lenk;
      lenk1_r  <= g_lenk1;
    end
    if (res_load) begin
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_offset = out_data_r;
  assign out_status      = out_status_r;

endmodule

// ===== src/fca_cell.sv =====
// One free-extent cell of the sorted extent chain: start, length, valid.
// Depends on fca_pkg for the command struct.
module fca_cell #(
  parameter int          SW        = 18,
  parameter int          LW        = 17,
  parameter int          KW        = 19,
  parameter bit          RST_VALID = 1'b0,
  parameter logic [LW-1:0] RST_LEN = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fca_pkg::cell_cmd_t cmd,
  input  logic              pos_i,
  input  logic              after_i,
  input  logic [SW-1:0]     w_start,
  input  logic [LW-1:0]     w_len,
  input  logic              l_valid,
  input  logic [SW-1:0]     l_start,
  input  logic [LW-1:0]     l_len,
  input  logic              r_valid,
  input  logic [SW-1:0]     r_start,
  input  logic [LW-1:0]     r_len,
  input  logic [KW-1:0]     probe_size,
  input  logic [KW-1:0]     probe_end,
  input  logic [KW-1:0]     probe_base,
  output logic              valid_o,
  output logic [SW-1:0]     start_o,
  output logic [LW-1:0]     len_o,
  output logic              fit_o,
  output logic              gt_o,
  output logic              eq_o,
  output logic              adj_o
);
  import fca_pkg::*;

  logic          valid_r, valid_nxt;
  logic [SW-1:0] start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          fit_r, gt_r, eq_r, adj_r;

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    case (cmd.op)
      OP_WRITE: begin
        if (pos_i) begin
          valid_nxt = 1'b1;
          start_nxt = w_start;
          len_nxt   = w_len;
        end
      end
      OP_INSERT: begin
        if (pos_i) begin
          valid_nxt = 1'b1;
          start_nxt = w_start;
          len_nxt   = w_len;
        end else if (after_i) begin
          valid_nxt = l_valid;
          start_nxt = l_start;
          len_nxt   = l_len;
        end
      end
      OP_REMOVE: begin
        if (pos_i || after_i) begin
          valid_nxt = r_valid;
          start_nxt = r_start;
          len_nxt   = r_len;
        end
      end
      OP_INIT: begin
        valid_nxt = pos_i & cmd.load_valid;
        start_nxt = w_start;
        len_nxt   = w_len;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= RST_VALID;
      start_r <= '0;
      len_r   <= RST_LEN;
    end else begin
      valid_r <= valid_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
    fit_r <= valid_r && (KW'(len_r) >= probe_size);
    gt_r  <= probe_end > KW'(start_r);
    eq_r  <= probe_end == KW'(start_r);
    adj_r <= (KW'(start_r) + KW'(len_r)) == probe_base;
  end

  assign valid_o = valid_r;
  assign start_o = start_r;
  assign len_o   = len_r;
  assign fit_o   = fit_r;
  assign gt_o    = gt_r;
  assign eq_o    = eq_r;
  assign adj_o   = adj_r;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the first-fit coalescing allocator: directed, table-full and random tests.
// Checks every result word against an in-bench allocator predictor.
// Depends on fca_pkg and first_fit_coalescing_allocator_top.
`timescale 1ns / 100ps

module tb;
  import fca_pkg::*;

  localparam int unsigned ARENA   = 65536;
  localparam int unsigned ALIGN   = 16;
  localparam int unsigned HDR     = 16;
  localparam int unsigned MIN_FR  = 16;
  localparam int unsigned MAX_EXT = 64;
  localparam int unsigned SLOTS   = ARENA / ALIGN;
  localparam int unsigned LEN_MAX = 2 * ARENA - 1;
  localparam int unsigned SETTLE  = 16;    // cycles after the last result before idle
  localparam int unsigned WD_MAX  = 2000;  // cycles without any handshake

  typedef struct packed {
    logic [15:0] data;
    logic [1:0]  status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_ALLOC;
  logic [15:0] in_request_bytes = '0;
  logic [15:0] in_block_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_data_offset;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_active_pool_bytes = '0;

  first_fit_coalescing_allocator_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_request_bytes, .in_block_offset,
    .out_valid, .out_stall, .out_data_offset, .out_status,
    .cfg_valid, .cfg_ready, .cfg_active_pool_bytes
  );

  always #4 clk = ~clk;

  // Allocator predictor state
  int unsigned pool_bytes;
  int unsigned ext_base [MAX_EXT];
  int unsigned ext_len  [MAX_EXT];
  int unsigned ext_cnt;
  int unsigned size_of  [SLOTS];
  bit          size_set [SLOTS];

  grant_t      pending_grants[$];
  logic [15:0] live_blocks[$];

  bit          idle_on = 1'b1;
  int          errors = 0;
  int          n_words = 0;
  int          n_ok = 0, n_nofit = 0, n_bad = 0, n_full = 0, n_cfg = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  function automatic void load_pool(int unsigned v);
    if (v > ARENA) v = ARENA;
    pool_bytes  = v - v % ALIGN;
    ext_cnt     = (pool_bytes != 0) ? 1 : 0;
    ext_base[0] = 0;
    ext_len[0]  = pool_bytes;
  endfunction

  function automatic int unsigned len_add(int unsigned a, int unsigned b);
    return (a + b > LEN_MAX) ? LEN_MAX : a + b;
  endfunction

  function automatic void ext_insert(int unsigned p, int unsigned s, int unsigned l);
    for (int unsigned i = ext_cnt; i > p; i--) begin
      ext_base[i] = ext_base[i-1];
      ext_len[i]  = ext_len[i-1];
    end
    ext_base[p] = s;
    ext_len[p]  = l;
    ext_cnt++;
  endfunction

  function automatic void ext_remove(int unsigned p);
    for (int unsigned i = p; i + 1 < ext_cnt; i++) begin
      ext_base[i] = ext_base[i+1];
      ext_len[i]  = ext_len[i+1];
    end
    ext_cnt--;
  endfunction

  function automatic grant_t grant_block(int unsigned req);
    grant_t      g;
    int unsigned sz, i, base, rec;
    g = '{data: '0, status: STAT_OK};
    sz = req + HDR;
    if (sz < MIN_FR) sz = MIN_FR;
    sz = (sz + ALIGN - 1) / ALIGN * ALIGN;
    for (i = 0; i < ext_cnt; i++)
      if (ext_len[i] >= sz) break;
    if (i == ext_cnt) begin
      g.status = STAT_NOFIT;
      return g;
    end
    base = ext_base[i];
    if (ext_len[i] - sz >= MIN_FR) begin
      ext_base[i] += sz;
      ext_len[i]  -= sz;
      rec = sz;
    end else begin
      rec = ext_len[i];
      ext_remove(i);
    end
    if (base / ALIGN < SLOTS) begin
      size_of[base / ALIGN]  = rec;
      size_set[base / ALIGN] = 1'b1;
    end
    g.data = 16'(base + HDR);
    return g;
  endfunction

  function automatic logic offset_rejected(int unsigned off);
    return off < HDR || off >= pool_bytes || (off - HDR) % ALIGN != 0;
  endfunction

  function automatic logic [1:0] release_block(int unsigned off);
    int unsigned e, sz, fin, k;
    bit          nxt, prv;
    if (offset_rejected(off)) return STAT_BADADDR;
    e   = off - HDR;
    sz  = size_of[e / ALIGN];
    fin = e + sz;
    if (ext_cnt == 0 || fin < ext_base[0]) begin
      if (ext_cnt >= MAX_EXT) return STAT_FULL;
      ext_insert(0, e, sz);
      return STAT_OK;
    end
    if (fin == ext_base[0]) begin
      ext_base[0] = e;
      ext_len[0]  = len_add(ext_len[0], sz);
      return STAT_OK;
    end
    k = 0;
    while (k + 1 < ext_cnt && fin > ext_base[k+1]) k++;
    nxt = (k + 1 < ext_cnt) && fin == ext_base[k+1];
    prv = (ext_base[k] + ext_len[k] == e);
    if (!nxt && !prv && ext_cnt >= MAX_EXT) return STAT_FULL;
    if (nxt) begin
      sz = len_add(sz, ext_len[k+1]);
      ext_remove(k + 1);
    end
    if (prv) ext_len[k] = len_add(ext_len[k], sz);
    else ext_insert(k + 1, e, sz);
    return STAT_OK;
  endfunction

  // Send one request word; predict its result at the accepting edge.
  task automatic send_word(input logic m, input int unsigned req, input int unsigned off);
    grant_t g;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_request_bytes <= 16'(req);
    in_block_offset  <= 16'(off);
    do @(posedge clk); while (in_stall);
    if (m == MODE_ALLOC) begin
      g = grant_block(req);
      if (g.status == STAT_OK && g.data != 0) live_blocks.push_back(g.data);
    end else begin
      g = '{data: '0, status: release_block(off)};
    end
    pending_grants.push_back(g);
    n_words++;
  endtask

  task automatic alloc_req(input int unsigned req);
    send_word(MODE_ALLOC, req, $urandom_range(0, 65535));
  endtask

  task automatic free_req(input int unsigned off);
    send_word(MODE_FREE, $urandom_range(0, 65535), off);
  endtask

  // Drop valid, wait for every expected word, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool(input int unsigned v);
    drain();
    cfg_valid             <= 1'b1;
    cfg_active_pool_bytes <= 17'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_pool(v);
    live_blocks.delete();
    n_cfg++;
  endtask

  // Result checker: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result data=%0d status=%0d", out_data_offset, out_status);
      end else begin
        g = pending_grants.pop_front();
        if (out_data_offset !== g.data || out_status !== g.status) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: expected data=%0d status=%0d, got data=%0d status=%0d",
                     g.data, g.status, out_data_offset, out_status);
        end
        case (g.status)
          STAT_OK:      n_ok++;
          STAT_NOFIT:   n_nofit++;
          STAT_BADADDR: n_bad++;
          default:      n_full++;
        endcase
      end
    end
  end

  // Result-side backpressure in bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_MAX) begin
      $display("Timeout after %0d idle cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Field extremes, merges on each side, bad offsets, split/whole, end of arena.
  task automatic test_directed;
    alloc_req(0);          // data 16
    alloc_req(0);          // data 32
    alloc_req(0);          // data 48
    free_req(16);          // insert ahead of the tail extent
    free_req(48);          // merge with following extent
    free_req(32);          // merge with both neighbors
    alloc_req(65535);      // oversized: no fit
    alloc_req(1);
    free_req(0);           // below header
    free_req(8);
    free_req(17);          // misaligned
    free_req(65535);       // misaligned, near the top of the pool
    free_req(16);          // free of the block just granted
    write_pool(48);
    alloc_req(10);         // split, remainder exactly one free entry
    alloc_req(0);          // take the rest whole
    alloc_req(0);          // empty list
    write_pool(65536);
    alloc_req(65504);      // leaves the last 16 bytes
    alloc_req(0);          // data offset wraps to zero
    free_req(0);
    write_pool(0);
    alloc_req(0);
    free_req(16);
  endtask

  // Fragment the pool until the extent table fills, then merge a hole closed.
  task automatic test_table_full;
    write_pool(65536);
    for (int i = 0; i < 130; i++) alloc_req(0);
    for (int i = 0; i < 130; i += 2) free_req(HDR + i * 16);
    free_req(HDR + 16);
    free_req(HDR + 128 * 16 + 16);
  endtask

  task automatic test_random(input int unsigned pool_val, input int n);
    int unsigned r, req, off, k;
    write_pool(pool_val);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 99);
        if (r < 80) req = $urandom_range(0, 200);
        else if (r < 96) req = $urandom_range(0, 6000);
        else req = $urandom_range(0, 65535);
        alloc_req(req);
      end else if (r < 90 && live_blocks.size() != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        off = live_blocks[k];
        live_blocks.delete(k);
        free_req(off);
      end else begin
        // noise: random offsets, never one whose size was never recorded
        off = $urandom_range(0, 65535);
        if (!offset_rejected(off) && !size_set[(off - HDR) / ALIGN]) off = off | 1;
        free_req(off);
      end
    end
  endtask

  initial begin
    load_pool(ARENA);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(65536, 80);
    test_random(4096, 300);
    test_random(1000, 250);
    test_random(131071, 250);
    test_random(48, 100);
    test_random(2048, 250);
    idle_on = 1'b0;
    test_random(8192, 300);
    drain();
    $display("Covered %0d request words over %0d pool settings.", n_words, n_cfg);
    $display("Results: %0d ok, %0d no fit, %0d bad offset, %0d table full; %0d mismatches.",
             n_ok, n_nofit, n_bad, n_full, errors);
    if (errors == 0 && pending_grants.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
